[sv/mnp_pkg.sv]
// shared types, constants and helpers for the memory node placement block
`default_nettype none
package mnp_pkg;

    localparam int MAX_NODES = 16;
    localparam int NODE_W    = 4;
    localparam int NCNT_W    = 5;
    localparam int QDEPTH    = 2;
    localparam int WSUM_W    = 20;
    localparam int RND_W     = 31;

    localparam logic [15:0]      DEFAULT_WEIGHT = 16'd100;
    localparam logic [RND_W-1:0] PRESSURE_LIMIT = 31'h4000_0000;

    typedef enum logic [1:0] {
        CMD_ALLOC     = 2'd0,
        CMD_WR_STATIC = 2'd1,
        CMD_WR_PRESS  = 2'd2,
        CMD_READ      = 2'd3
    } t_cmd;

    localparam logic [3:0] STRAT_LOCAL  = 4'd0;
    localparam logic [3:0] STRAT_INTER  = 4'd1;
    localparam logic [3:0] STRAT_RR     = 4'd2;
    localparam logic [3:0] STRAT_WEIGHT = 4'd3;
    localparam logic [3:0] STRAT_PRESS  = 4'd4;
    localparam logic [3:0] STRAT_SPLIT  = 4'd5;
    localparam logic [3:0] STRAT_WINTER = 4'd6;

    localparam logic [3:0] CFG_STRATEGY   = 4'd0;
    localparam logic [3:0] CFG_NODE_COUNT = 4'd1;
    localparam logic [3:0] CFG_MASK       = 4'd2;
    localparam logic [3:0] CFG_SMALL_LIM  = 4'd3;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SUM,
        B_DIV,
        B_PICK,
        B_PRESS,
        B_DONE
    } t_bstate;

    typedef struct packed {
        t_cmd              cmd;
        logic [NODE_W-1:0] idx;
        logic [47:0]       size;
        logic [15:0]       weight;
        logic [RND_W-1:0]  rnd;
        logic [MAX_NODES-1:0] en;
        logic [NCNT_W-1:0] n;
        logic [3:0]        strat;
        logic              is_small;
    } t_item;

    typedef struct packed {
        logic [1:0] count;
        logic       full;
    } t_fstat;

    typedef struct packed {
        logic take;
        logic busy;
    } t_bstat;

    // lowest set bit, zero when none
    function automatic logic [NODE_W-1:0] first_set(input logic [MAX_NODES-1:0] v);
        logic [NODE_W-1:0] r;
        r = '0;
        for (int i = MAX_NODES - 1; i >= 0; i--) begin
            if (v[i]) r = NODE_W'(i);
        end
        return r;
    endfunction

    // first enabled node at or after start, wrapping
    function automatic logic [NODE_W-1:0] next_on(input logic [MAX_NODES-1:0] en,
                                                 input logic [NODE_W-1:0] start);
        logic [MAX_NODES-1:0] m;
        m = en & ~((MAX_NODES'(1) << start) - MAX_NODES'(1));
        return (m != '0) ? first_set(m) : first_set(en);
    endfunction

endpackage
`default_nettype wire

[sv/memory_node_placement_policy.sv]
// top level of the memory node placement block: config registers, front end, back end
// sequence: writes, reads and direct strategies go straight to the result; round robin runs
//   the remainder unit; pressure aware walks the nodes; weighted and interleave run the
//   sum walk, 31-step remainder and pick walk
// the back end holds one beat at a time and takes no new beat until the last is through;
//   a two-entry queue keeps taking input meanwhile
// reset: synchronous active low; weights return to 100, counters and round robin pointer to zero
`default_nettype none
module memory_node_placement_policy (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [3:0]  i_node_index,
    input  wire logic [47:0] i_alloc_size,
    input  wire logic [15:0] i_weight_value,
    input  wire logic [30:0] i_rand_value,
    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [3:0]       o_chosen_node,
    output logic [31:0]      o_alloc_count,
    output logic [63:0]      o_byte_count,
    // configuration write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [3:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);
    import mnp_pkg::*;

    // configuration registers
    logic [3:0]  r_strategy;
    logic [4:0]  r_node_count;
    logic [15:0] r_enabled_mask;
    logic [31:0] r_small_size_limit;

    t_item  w_item;
    logic   w_item_valid, w_take;
    t_fstat w_fstat;
    t_bstat w_bstat;

    // writes are always accepted and land in the register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strategy         <= STRAT_WINTER;
            r_node_count       <= 5'(MAX_NODES);
            r_enabled_mask     <= '0;
            r_small_size_limit <= 32'd1024;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_STRATEGY:   r_strategy         <= i_cfg_data[3:0];
                CFG_NODE_COUNT: r_node_count       <= i_cfg_data[4:0];
                CFG_MASK:       r_enabled_mask     <= i_cfg_data[15:0];
                CFG_SMALL_LIM:  r_small_size_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // front end: enable vector, node count clamp and size class worked out per beat
    mnp_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_cmd              (i_cmd),
        .i_node_index       (i_node_index),
        .i_alloc_size       (i_alloc_size),
        .i_weight_value     (i_weight_value),
        .i_rand_value       (i_rand_value),
        .i_strategy         (r_strategy),
        .i_node_count       (r_node_count),
        .i_enabled_mask     (r_enabled_mask),
        .i_small_size_limit (r_small_size_limit),
        .o_item             (w_item),
        .o_item_valid       (w_item_valid),
        .i_take             (w_take),
        .o_stat             (w_fstat)
    );

    // back end: node walks, shared remainder unit, counter update and result register
    mnp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (w_item),
        .i_item_valid  (w_item_valid),
        .o_take        (w_take),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_chosen_node (o_chosen_node),
        .o_alloc_count (o_alloc_count),
        .o_byte_count  (o_byte_count),
        .o_stat        (w_bstat)
    );

    // queue never holds more than its depth
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fstat.count <= 2'(QDEPTH))
        else $error("queue overfilled");

    // back end only takes a beat that the queue holds
    a_take_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_bstat.take |-> (w_fstat.count != '0))
        else $error("take from empty queue");

    // a taken beat leaves the back end busy on the next cycle
    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_bstat.take |=> w_bstat.busy)
        else $error("back end not busy after take");

    // no result straight out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid after reset");

endmodule
`default_nettype wire

[sv/mnp_front.sv]
// front end: accepts beats, classifies them and queues them for the back end
`default_nettype none
module mnp_front (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_stall,
    input  wire logic [1:0]              i_cmd,
    input  wire logic [3:0]              i_node_index,
    input  wire logic [47:0]             i_alloc_size,
    input  wire logic [15:0]             i_weight_value,
    input  wire logic [30:0]             i_rand_value,
    input  wire logic [3:0]              i_strategy,
    input  wire logic [4:0]              i_node_count,
    input  wire logic [15:0]             i_enabled_mask,
    input  wire logic [31:0]             i_small_size_limit,
    output mnp_pkg::t_item               o_item,
    output logic                         o_item_valid,
    input  wire logic                    i_take,
    output mnp_pkg::t_fstat              o_stat
);
    import mnp_pkg::*;

    t_item              w_item;
    logic [NCNT_W-1:0]  w_n;
    t_item              r_q [QDEPTH];
    logic               r_wp, r_rp;
    logic [1:0]         r_cnt;
    logic               w_push, w_pop;

    always_comb begin
        if (i_node_count == '0) begin
            w_n = NCNT_W'(1);
        end else if (i_node_count > NCNT_W'(MAX_NODES)) begin
            w_n = NCNT_W'(MAX_NODES);
        end else begin
            w_n = i_node_count;
        end
    end

    always_comb begin
        w_item.cmd      = t_cmd'(i_cmd);
        w_item.idx      = i_node_index;
        w_item.size     = i_alloc_size;
        w_item.weight   = i_weight_value;
        w_item.rnd      = i_rand_value;
        w_item.n        = w_n;
        w_item.strat    = i_strategy;
        w_item.is_small = i_alloc_size < {16'd0, i_small_size_limit};
        for (int i = 0; i < MAX_NODES; i++) begin
            w_item.en[i] = (NCNT_W'(i) < w_n) &&
                           ((i_enabled_mask == '0) || i_enabled_mask[i]);
        end
    end

    assign o_in_stall   = (r_cnt == 2'(QDEPTH));
    assign w_push       = i_in_valid && !o_in_stall;
    assign w_pop        = i_take && (r_cnt != '0);
    assign o_item_valid = (r_cnt != '0);
    assign o_item       = r_q[r_rp];
    assign o_stat.count = r_cnt;
    assign o_stat.full  = o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_q[r_wp] <= w_item;
                r_wp      <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

endmodule
`default_nettype wire

[sv/mnp_back.sv]
// back end: node selection sequencer, weight and counter state, result register
`default_nettype none
module mnp_back (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  mnp_pkg::t_item               i_item,
    input  wire logic                    i_item_valid,
    output logic                         o_take,
    input  wire logic                    i_out_stall,
    output logic                         o_out_valid,
    output logic [3:0]                   o_chosen_node,
    output logic [31:0]                  o_alloc_count,
    output logic [63:0]                  o_byte_count,
    output mnp_pkg::t_bstat              o_stat
);
    import mnp_pkg::*;

    t_bstate            r_state, n_state;
    t_item              r_item;
    logic [15:0]        r_sw [MAX_NODES];
    logic [15:0]        r_pw [MAX_NODES];
    logic [31:0]        r_ac [MAX_NODES];
    logic [63:0]        r_bc [MAX_NODES];
    logic [NCNT_W-1:0]  r_rr;
    logic [NODE_W-1:0]  r_ptr, r_sel;
    logic [WSUM_W-1:0]  r_total, r_cum, r_rem, r_div;
    logic [RND_W-1:0]   r_dvd;
    logic [4:0]         r_dcnt;
    logic [RND_W-1:0]   r_best;
    logic               r_out_valid;
    logic [3:0]         r_out_node;
    logic [31:0]        r_out_ac;
    logic [63:0]        r_out_bc;

    logic [NODE_W-1:0]  w_addr, w_first, w_fix, w_start, w_fi_in, w_sel_in, w_rr_sel;
    logic [15:0]        w_sw, w_pw;
    logic [31:0]        w_ac;
    logic [63:0]        w_bc;
    logic [WSUM_W-1:0]  w_w, w_add, w_sum_next, w_cum_next, w_rem_next;
    logic [WSUM_W:0]    w_shift, w_sub;
    logic               w_here, w_last, w_hit, w_out_free, w_alloc;

    assign w_alloc    = (r_item.cmd == CMD_ALLOC);
    assign w_first    = first_set(r_item.en);
    assign w_fix      = (!w_alloc || r_item.en[r_sel]) ? r_sel : w_first;
    assign w_addr     = (r_state == B_DONE) ? w_fix : r_ptr;
    assign w_sw       = r_sw[w_addr];
    assign w_pw       = r_pw[w_addr];
    assign w_ac       = r_ac[w_addr];
    assign w_bc       = r_bc[w_addr];
    assign w_here     = r_item.en[r_ptr];
    assign w_last     = (r_ptr == NODE_W'(MAX_NODES - 1));
    assign w_out_free = !r_out_valid || !i_out_stall;

    // interleave is a weighted pick with unit weights
    always_comb begin
        case (r_item.strat)
            STRAT_INTER:  w_w = WSUM_W'(1);
            STRAT_WEIGHT: w_w = {4'd0, w_sw};
            default:      w_w = {4'd0, w_pw};
        endcase
    end

    assign w_add      = w_here ? w_w : '0;
    assign w_sum_next = r_total + w_add;
    assign w_cum_next = r_cum + w_add;
    assign w_hit      = w_here && (r_rem < w_cum_next);

    // one restoring step of the remainder unit
    assign w_shift    = {r_rem, r_dvd[r_dcnt]};
    assign w_sub      = w_shift - {1'b0, r_div};
    assign w_rem_next = (w_shift >= {1'b0, r_div}) ? w_sub[WSUM_W-1:0]
                                                    : w_shift[WSUM_W-1:0];
    assign w_rr_sel   = next_on(r_item.en, w_rem_next[NODE_W-1:0]);

    // direct choices made as the item is taken
    assign w_fi_in = first_set(i_item.en);
    assign w_start = (i_item.n == NCNT_W'(1)) ? NODE_W'(0) : NODE_W'(1);
    always_comb begin
        case (i_item.strat)
            STRAT_LOCAL: w_sel_in = i_item.en[0] ? '0 : w_fi_in;
            STRAT_SPLIT: w_sel_in = i_item.is_small ? (i_item.en[0] ? '0 : w_fi_in)
                                                    : next_on(i_item.en, w_start);
            default:     w_sel_in = w_fi_in;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (i_item_valid) begin
                    if (i_item.cmd != CMD_ALLOC) begin
                        n_state = B_DONE;
                    end else begin
                        case (i_item.strat)
                            STRAT_INTER, STRAT_WEIGHT, STRAT_WINTER: n_state = B_SUM;
                            STRAT_RR:    n_state = B_DIV;
                            STRAT_PRESS: n_state = B_PRESS;
                            default:     n_state = B_DONE;
                        endcase
                    end
                end
            end
            B_SUM: begin
                if (w_last) n_state = (w_sum_next == '0) ? B_DONE : B_DIV;
            end
            B_DIV: begin
                if (r_dcnt == '0) n_state = (r_item.strat == STRAT_RR) ? B_DONE : B_PICK;
            end
            B_PICK: begin
                if (w_hit || w_last) n_state = B_DONE;
            end
            B_PRESS: begin
                if (w_last) n_state = B_DONE;
            end
            B_DONE: begin
                if (w_out_free) n_state = B_IDLE;
            end
            default: n_state = B_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_take      = (r_state == B_IDLE) && i_item_valid;
        o_stat.take = o_take;
        o_stat.busy = (r_state != B_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_rr        <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < MAX_NODES; i++) begin
                r_sw[i] <= DEFAULT_WEIGHT;
                r_pw[i] <= DEFAULT_WEIGHT;
                r_ac[i] <= '0;
                r_bc[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            // result register: loaded from the done state, cleared once taken
            if (r_state == B_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (i_item_valid) begin
                        r_item  <= i_item;
                        r_ptr   <= '0;
                        r_total <= '0;
                        r_cum   <= '0;
                        r_rem   <= '0;
                        r_best  <= PRESSURE_LIMIT;
                        r_dcnt  <= 5'(RND_W - 1);
                        if (i_item.cmd != CMD_ALLOC) begin
                            r_sel <= i_item.idx;
                            if (i_item.cmd == CMD_WR_STATIC) r_sw[i_item.idx] <= i_item.weight;
                            if (i_item.cmd == CMD_WR_PRESS)  r_pw[i_item.idx] <= i_item.weight;
                        end else begin
                            r_sel <= w_sel_in;
                        end
                        if (i_item.strat == STRAT_RR) begin
                            r_dvd <= RND_W'(r_rr);
                            r_div <= WSUM_W'(i_item.n);
                        end else begin
                            r_dvd <= i_item.rnd;
                        end
                    end
                end
                B_SUM: begin
                    r_total <= w_sum_next;
                    r_div   <= w_sum_next;
                    r_ptr   <= r_ptr + NODE_W'(1);
                end
                B_DIV: begin
                    r_rem  <= w_rem_next;
                    r_dcnt <= r_dcnt - 5'd1;
                    if (r_dcnt == '0 && r_item.strat == STRAT_RR) begin
                        r_sel <= w_rr_sel;
                        r_rr  <= NCNT_W'(w_rr_sel) + NCNT_W'(1);
                    end
                end
                B_PICK: begin
                    r_cum <= w_cum_next;
                    r_ptr <= r_ptr + NODE_W'(1);
                    if (w_hit) r_sel <= r_ptr;
                end
                B_PRESS: begin
                    r_ptr <= r_ptr + NODE_W'(1);
                    if (w_here && (w_bc < {33'd0, r_best})) begin
                        r_best <= w_bc[RND_W-1:0];
                        r_sel  <= r_ptr;
                    end
                end
                B_DONE: begin
                    if (w_out_free) begin
                        r_out_node  <= w_fix;
                        if (w_alloc) begin
                            r_ac[w_fix] <= w_ac + 32'd1;
                            r_bc[w_fix] <= w_bc + {16'd0, r_item.size};
                            r_out_ac    <= w_ac + 32'd1;
                            r_out_bc    <= w_bc + {16'd0, r_item.size};
                        end else begin
                            r_out_ac <= w_ac;
                            r_out_bc <= w_bc;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_chosen_node = r_out_node;
    assign o_alloc_count = r_out_ac;
    assign o_byte_count  = r_out_bc;

endmodule
`default_nettype wire

[verif/tb_memory_node_placement_policy.sv]
// self-checking testbench for the memory node placement block
`default_nettype none
module tb_memory_node_placement_policy;
    import mnp_pkg::*;

    // generous ceiling on the whole run, far above the slowest correct run
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RANDOM_ITEMS = 600;
    // longest back end latency plus margin, used before config writes and at the end
    localparam int SETTLE_CYCLES = 80;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_cmd;
    logic [3:0]  i_node_index;
    logic [47:0] i_alloc_size;
    logic [15:0] i_weight_value;
    logic [30:0] i_rand_value;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [3:0]  o_chosen_node;
    logic [31:0] o_alloc_count;
    logic [63:0] o_byte_count;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [3:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    memory_node_placement_policy dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_cmd          (i_cmd),
        .i_node_index   (i_node_index),
        .i_alloc_size   (i_alloc_size),
        .i_weight_value (i_weight_value),
        .i_rand_value   (i_rand_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_chosen_node  (o_chosen_node),
        .o_alloc_count  (o_alloc_count),
        .o_byte_count   (o_byte_count),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // clock: period 10
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // one result beat: node plus its counters after the update
    typedef struct packed {
        logic [3:0]  node;
        logic [31:0] allocs;
        logic [63:0] bytes_used;
    } placement_t;

    typedef enum logic {ROW_CFG, ROW_REQ} row_kind_t;

    // directed row: either a register write or a request, optionally with a typed-in answer
    typedef struct packed {
        row_kind_t   kind;
        logic [3:0]  reg_index;
        logic [31:0] reg_data;
        t_cmd        cmd;
        logic [3:0]  idx;
        logic [47:0] size;
        logic [15:0] weight;
        logic [30:0] rnd;
        logic        typed;
        placement_t  answer;
    } stim_row_t;

    // shadow of the block: registers and per-node state
    logic [3:0]  sh_strategy;
    logic [4:0]  sh_node_count;
    logic [15:0] sh_mask;
    logic [31:0] sh_small_limit;
    logic [4:0]  sh_rr_next;
    logic [15:0] sh_static_w [MAX_NODES];
    logic [15:0] sh_press_w  [MAX_NODES];
    logic [31:0] sh_allocs   [MAX_NODES];
    logic [63:0] sh_bytes    [MAX_NODES];

    placement_t pending_placements[$];
    int mismatches;
    int results_seen;
    int requests_sent;
    int cycles;
    bit quiet_sink;

    // effective node count, clamped to 1..MAX_NODES
    function automatic int live_nodes();
        if (sh_node_count == 0) return 1;
        if (sh_node_count > MAX_NODES) return MAX_NODES;
        return sh_node_count;
    endfunction

    function automatic bit node_on(int node, int n);
        if (node >= n) return 0;
        if (sh_mask == 16'd0) return 1;
        return sh_mask[node];
    endfunction

    function automatic int first_on(int n);
        for (int i = 0; i < n; i++) if (node_on(i, n)) return i;
        return 0;
    endfunction

    function automatic int wrap_on(int start, int n);
        int node;
        for (int i = 0; i < n; i++) begin
            node = (start + i) % n;
            if (node_on(node, n)) return node;
        end
        return 0;
    endfunction

    function automatic int nth_on(int nth, int n);
        int seen;
        seen = 0;
        for (int i = 0; i < n; i++) begin
            if (node_on(i, n)) begin
                if (seen == nth) return i;
                seen++;
            end
        end
        return first_on(n);
    endfunction

    // weighted draw over the first lim nodes, press selects the weight table
    function automatic int weighted_draw(bit press, int lim, int n, logic [30:0] rnd,
                                         int fallback);
        logic [31:0] total;
        logic [31:0] cum;
        logic [31:0] r;
        logic [15:0] w;
        total = 0;
        cum = 0;
        for (int i = 0; i < lim; i++) begin
            w = press ? sh_press_w[i] : sh_static_w[i];
            if (node_on(i, n)) total += w;
        end
        if (total == 0) return fallback;
        r = {1'b0, rnd} % total;
        for (int i = 0; i < lim; i++) begin
            w = press ? sh_press_w[i] : sh_static_w[i];
            if (node_on(i, n)) begin
                cum += w;
                if (r < cum) return i;
            end
        end
        return fallback;
    endfunction

    // places one request and updates the shadow state
    function automatic placement_t place_request(t_cmd cmd, logic [3:0] idx,
                                                 logic [47:0] size, logic [15:0] weight,
                                                 logic [30:0] rnd);
        placement_t p;
        int n;
        int sel;
        int cnt;
        logic [63:0] best;
        n = live_nodes();
        if (cmd == CMD_ALLOC) begin
            sel = first_on(n);
            case (sh_strategy)
                STRAT_LOCAL: sel = node_on(0, n) ? 0 : first_on(n);
                STRAT_INTER: begin
                    cnt = 0;
                    for (int i = 0; i < n; i++) if (node_on(i, n)) cnt++;
                    if (cnt == 0) cnt = 1;
                    sel = nth_on(rnd % cnt, n);
                end
                STRAT_RR: begin
                    sel = wrap_on(sh_rr_next, n);
                    sh_rr_next = 5'(sel + 1);
                end
                STRAT_WEIGHT: sel = weighted_draw(0, n, n, rnd, sel);
                STRAT_PRESS: begin
                    // least loaded, only counters strictly below 2^30 qualify
                    best = 64'd1 << 30;
                    for (int i = 0; i < n; i++) begin
                        if (node_on(i, n) && sh_bytes[i] < best) begin
                            best = sh_bytes[i];
                            sel = i;
                        end
                    end
                end
                STRAT_SPLIT: begin
                    if (size < {16'd0, sh_small_limit}) sel = node_on(0, n) ? 0 : first_on(n);
                    else sel = wrap_on(1, n);
                end
                STRAT_WINTER: sel = weighted_draw(1, (n < 16) ? n : 16, n, rnd, sel);
                default: sel = first_on(n);
            endcase
            if (!node_on(sel, n)) sel = first_on(n);
            sh_allocs[sel] += 1;
            sh_bytes[sel] += {16'd0, size};
            p.node = 4'(sel);
        end else begin
            if (cmd == CMD_WR_STATIC) sh_static_w[idx] = weight;
            else if (cmd == CMD_WR_PRESS) sh_press_w[idx] = weight;
            p.node = idx;
        end
        p.allocs = sh_allocs[p.node];
        p.bytes_used = sh_bytes[p.node];
        return p;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
        return $urandom_range(5, 30);
    endfunction

    // cycle counter and timeout
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     pending_placements.size());
            $display("FAIL memory_node_placement_policy");
            $finish;
        end
    end

    // result side back-pressure, changed on the falling edge
    int stall_left;
    always @(negedge i_clk) begin
        if (quiet_sink || !i_rst_n) begin
            i_out_stall = 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall = 1'b1;
        end else if ($urandom_range(0, 3) == 0) begin
            stall_left = gap_len();
            i_out_stall = 1'b1;
        end else begin
            i_out_stall = 1'b0;
        end
    end

    // result checker: compare each accepted beat with the oldest expectation
    always @(posedge i_clk) begin
        placement_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (pending_placements.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result node %0d allocs %0d bytes %0d",
                             o_chosen_node, o_alloc_count, o_byte_count);
            end else begin
                want = pending_placements.pop_front();
                if (want.node !== o_chosen_node || want.allocs !== o_alloc_count ||
                    want.bytes_used !== o_byte_count) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected node %0d allocs %0d bytes %0d, got node %0d allocs %0d bytes %0d",
                                 want.node, want.allocs, want.bytes_used,
                                 o_chosen_node, o_alloc_count, o_byte_count);
                end
            end
        end
    end

    // waits for every result, then lets the back end settle
    task automatic drain();
        while (pending_placements.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // one register write, called on a falling edge with the block idle
    task automatic write_reg(logic [3:0] index, logic [31:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = index;
        i_cfg_data = data;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        case (index)
            CFG_STRATEGY:   sh_strategy = data[3:0];
            CFG_NODE_COUNT: sh_node_count = data[4:0];
            CFG_MASK:       sh_mask = data[15:0];
            CFG_SMALL_LIM:  sh_small_limit = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // one request beat; returns on the falling edge after acceptance with valid still high
    task automatic send_request(t_cmd cmd, logic [3:0] idx, logic [47:0] size,
                                logic [15:0] weight, logic [30:0] rnd, bit typed,
                                placement_t answer);
        placement_t p;
        i_in_valid = 1'b1;
        i_cmd = cmd;
        i_node_index = idx;
        i_alloc_size = size;
        i_weight_value = weight;
        i_rand_value = rnd;
        forever begin
            @(posedge i_clk);
            if (!o_in_stall) break;
        end
        p = place_request(cmd, idx, size, weight, rnd);
        pending_placements.push_back(typed ? answer : p);
        requests_sent++;
        @(negedge i_clk);
    endtask

    task automatic idle_sender(int gap);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    function automatic logic [47:0] pick_size();
        case ($urandom_range(0, 5))
            0: return 48'($urandom_range(0, 2047));
            1: return {16'($urandom), 32'($urandom)};
            2: return 48'(sh_small_limit) + 48'($urandom_range(0, 2)) - 48'd1;
            3: return 48'($urandom_range(1 << 20, 1 << 28));
            4: return $urandom_range(0, 1) ? 48'hFFFF_FFFF_FFFF : 48'd0;
            default: return 48'($urandom_range(0, 1 << 16));
        endcase
    endfunction

    function automatic logic [31:0] pick_reg(logic [3:0] index);
        case (index)
            CFG_STRATEGY:   return $urandom_range(0, 9) < 8 ? $urandom_range(0, 6)
                                                            : $urandom_range(7, 15);
            CFG_NODE_COUNT: case ($urandom_range(0, 5))
                                0: return 0;
                                1: return 1;
                                2: return $urandom_range(17, 31);
                                default: return 16;
                            endcase
            CFG_MASK:       case ($urandom_range(0, 5))
                                0: return 0;
                                1: return 16'hFFFF;
                                2: return 32'd1 << $urandom_range(0, 15);
                                default: return $urandom_range(0, 16'hFFFF);
                            endcase
            default:        case ($urandom_range(0, 4))
                                0: return 0;
                                1: return 32'hFFFF_FFFF;
                                2: return 1024;
                                default: return $urandom;
                            endcase
        endcase
    endfunction

    stim_row_t directed_rows[$];

    function automatic stim_row_t cfg_row(logic [3:0] index, logic [31:0] data);
        stim_row_t r;
        r = '0;
        r.kind = ROW_CFG;
        r.reg_index = index;
        r.reg_data = data;
        return r;
    endfunction

    function automatic stim_row_t req_row(t_cmd cmd, logic [3:0] idx, logic [47:0] size,
                                          logic [15:0] weight, logic [30:0] rnd,
                                          bit typed, placement_t answer);
        stim_row_t r;
        r.kind = ROW_REQ;
        r.reg_index = '0;
        r.reg_data = '0;
        r.cmd = cmd;
        r.idx = idx;
        r.size = size;
        r.weight = weight;
        r.rnd = rnd;
        r.typed = typed;
        r.answer = answer;
        return r;
    endfunction

    initial begin
        placement_t none;
        int phase_len;
        int phases;
        int gap;
        bit quiet_src;
        t_cmd cmd;

        none = '0;
        cycles = 0;
        mismatches = 0;
        results_seen = 0;
        requests_sent = 0;
        stall_left = 0;
        phases = 0;
        quiet_sink = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_cmd = CMD_ALLOC;
        i_node_index = '0;
        i_alloc_size = '0;
        i_weight_value = '0;
        i_rand_value = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;

        // shadow reset state
        sh_strategy = STRAT_WINTER;
        sh_node_count = 5'd16;
        sh_mask = '0;
        sh_small_limit = 32'd1024;
        sh_rr_next = '0;
        for (int i = 0; i < MAX_NODES; i++) begin
            sh_static_w[i] = DEFAULT_WEIGHT;
            sh_press_w[i] = DEFAULT_WEIGHT;
            sh_allocs[i] = '0;
            sh_bytes[i] = '0;
        end

        // directed table: reset values, field extremes, each strategy and corner case
        directed_rows.push_back(req_row(CMD_READ, 4'd0, '0, '0, '0, 1, '{4'd0, 32'd0, 64'd0}));
        directed_rows.push_back(req_row(CMD_READ, 4'd15, '0, '0, '0, 1, '{4'd15, 32'd0, 64'd0}));
        // equal pressure weights, zero draw lands on node 0
        directed_rows.push_back(req_row(CMD_ALLOC, 4'd7, 48'd0, '0, 31'd0, 1,
                                        '{4'd0, 32'd1, 64'd0}));
        directed_rows.push_back(req_row(CMD_ALLOC, 4'd0, 48'hFFFF_FFFF_FFFF, 16'hFFFF,
                                        31'h7FFF_FFFF, 0, none));
        directed_rows.push_back(req_row(CMD_WR_STATIC, 4'd15, '0, 16'hFFFF, '0, 1,
                                        '{4'd15, 32'd0, 64'd0}));
        directed_rows.push_back(req_row(CMD_WR_PRESS, 4'd3, '0, 16'd0, '0, 1,
                                        '{4'd3, 32'd0, 64'd0}));
        directed_rows.push_back(req_row(CMD_ALLOC, 4'd0, 48'd12, '0, 31'd350, 0, none));
        directed_rows.push_back(cfg_row(CFG_STRATEGY, STRAT_LOCAL));
        directed_rows.push_back(req_row(CMD_ALLOC, 4'd0, 48'd64, '0, '0, 0, none));
        // local first with node 0 masked off
        directed_rows.push_back(cfg_row(CFG_MASK, 32'h0004));
        directed_rows.push_back(req_row(CMD_ALLOC, 4'd0, 48'd64, '0, '0, 0, none));
        directed_rows.push_back(cfg_row(CFG_STRATEGY, STRAT_INTER));
        directed_rows.push_back(cfg_row(CFG_MASK, 32'h8421));
        directed_rows.push_back(req_row(CMD_ALLOC, 4'd0, 48'd5, '0, 31'd6, 0, none));
        directed_rows.push_back(cfg_row(CFG_MASK, 32'hFFFF));
        directed_rows.push_back(cfg_row(CFG_STRATEGY, STRAT_RR));
        directed_rows.push_back(req_row(CMD_ALLOC, 4'd0, 48'd1, '0, '0, 0, none));
        directed_rows.push_back(req_row(CMD_ALLOC, 4'd0, 48'd1, '0, '0, 0, none));
        // node count zero acts as one node, above the maximum acts as the maximum
        directed_rows.push_back(cfg_row(CFG_NODE_COUNT, 32'd0));
        directed_rows.push_back(req_row(CMD_ALLOC, 4'd0, 48'd2, '0, '0, 0, none));
        directed_rows.push_back(cfg_row(CFG_NODE_COUNT, 32'd31));
        directed_rows.push_back(req_row(CMD_ALLOC, 4'd0, 48'd2, '0, '0, 0, none));
        directed_rows.push_back(cfg_row(CFG_STRATEGY, STRAT_WEIGHT));
        directed_rows.push_back(req_row(CMD_ALLOC, 4'd0, 48'd3, '0, 31'h7FFF_FFFF, 0, none));
        directed_rows.push_back(cfg_row(CFG_STRATEGY, STRAT_PRESS));
        directed_rows.push_back(req_row(CMD_ALLOC, 4'd0, 48'h4000_0000, '0, '0, 0, none));
        // no enabled node at all: falls back to node 0
        directed_rows.push_back(cfg_row(CFG_MASK, 32'h8000));
        directed_rows.push_back(cfg_row(CFG_NODE_COUNT, 32'd4));
        directed_rows.push_back(req_row(CMD_ALLOC, 4'd0, 48'd9, '0, '0, 0, none));
        directed_rows.push_back(cfg_row(CFG_MASK, 32'd0));
        directed_rows.push_back(cfg_row(CFG_STRATEGY, STRAT_SPLIT));
        directed_rows.push_back(cfg_row(CFG_SMALL_LIM, 32'd0));
        directed_rows.push_back(req_row(CMD_ALLOC, 4'd0, 48'd0, '0, '0, 0, none));
        directed_rows.push_back(cfg_row(CFG_SMALL_LIM, 32'hFFFF_FFFF));
        directed_rows.push_back(req_row(CMD_ALLOC, 4'd0, 48'hFFFF_FFFE, '0, '0, 0, none));
        directed_rows.push_back(cfg_row(CFG_STRATEGY, 32'd15));
        directed_rows.push_back(req_row(CMD_ALLOC, 4'd0, 48'd4, '0, '0, 0, none));
        // weighted with all enabled weights zero takes the first enabled node
        directed_rows.push_back(cfg_row(CFG_STRATEGY, STRAT_WEIGHT));
        directed_rows.push_back(cfg_row(CFG_NODE_COUNT, 32'd2));
        directed_rows.push_back(req_row(CMD_WR_STATIC, 4'd0, '0, 16'd0, '0, 0, none));
        directed_rows.push_back(req_row(CMD_WR_STATIC, 4'd1, '0, 16'd0, '0, 0, none));
        directed_rows.push_back(req_row(CMD_ALLOC, 4'd0, 48'd8, '0, 31'd77, 0, none));

        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[k]) begin
            if (directed_rows[k].kind == ROW_CFG) begin
                i_in_valid = 1'b0;
                drain();
                write_reg(directed_rows[k].reg_index, directed_rows[k].reg_data);
            end else begin
                send_request(directed_rows[k].cmd, directed_rows[k].idx,
                             directed_rows[k].size, directed_rows[k].weight,
                             directed_rows[k].rnd, directed_rows[k].typed,
                             directed_rows[k].answer);
                idle_sender(gap_len());
            end
        end

        // random phases: the sender pauses until every result is back, then reconfigures
        while (requests_sent < directed_rows.size() + RANDOM_ITEMS) begin
            i_in_valid = 1'b0;
            drain();
            for (int r = 0; r < 4; r++) begin
                if (phases < 4 || $urandom_range(0, 1)) write_reg(4'(r), pick_reg(4'(r)));
            end
            phases++;
            quiet_src = ($urandom_range(0, 4) == 0);
            quiet_sink = ($urandom_range(0, 4) == 0);
            phase_len = $urandom_range(15, 60);
            for (int j = 0; j < phase_len; j++) begin
                case ($urandom_range(0, 9))
                    0: cmd = CMD_WR_STATIC;
                    1: cmd = CMD_WR_PRESS;
                    2: cmd = CMD_READ;
                    default: cmd = CMD_ALLOC;
                endcase
                send_request(cmd, 4'($urandom), pick_size(),
                             $urandom_range(0, 3) == 0 ? 16'($urandom_range(0, 1) * 16'hFFFF)
                                                       : 16'($urandom_range(0, 300)),
                             31'($urandom), 0, none);
                gap = quiet_src ? 0 : gap_len();
                idle_sender(gap);
            end
        end

        i_in_valid = 1'b0;
        quiet_sink = 1'b0;
        drain();
        $display("covered %0d requests (%0d results) over %0d random configurations",
                 requests_sent, results_seen, phases);
        $display("every strategy, node count and mask corner, with stalls on both channels");
        if (mismatches == 0 && pending_placements.size() == 0) begin
            $display("PASS memory_node_placement_policy");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches,
                     pending_placements.size());
            $display("FAIL memory_node_placement_policy");
        end
        $finish;
    end
endmodule
`default_nettype wire

[sim.f]
sv/mnp_pkg.sv
sv/mnp_front.sv
sv/mnp_back.sv
sv/memory_node_placement_policy.sv
verif/tb_memory_node_placement_policy.sv
